### rtl/mrv_pkg.sv
package mrv_pkg;

  // Function codes that get their own checks.
  localparam logic [7:0] FcWriteCoil = 8'd5;
  localparam logic [7:0] FcWriteReg  = 8'd6;

  // The only nonzero value a single coil write may carry.
  localparam logic [15:0] CoilOnValue = 16'hFF00;

  // Byte positions inside a request; PosIdle waits for the next frame start.
  localparam logic [2:0] PosSlave    = 3'd0;
  localparam logic [2:0] PosFunction = 3'd1;
  localparam logic [2:0] PosAddrHigh = 3'd2;
  localparam logic [2:0] PosAddrLow  = 3'd3;
  localparam logic [2:0] PosQtyHigh  = 3'd4;
  localparam logic [2:0] PosQtyLow   = 3'd5;
  localparam logic [2:0] PosIdle     = 3'd6;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegOwnSlave    = 2'd0;
  localparam logic [1:0] RegServedFunc  = 2'd1;
  localparam logic [1:0] RegWindowStart = 2'd2;
  localparam logic [1:0] RegWindowLen   = 2'd3;

  // Depth of the queue between front and back.
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    VOk       = 3'd0,
    VSlave    = 3'd1,
    VFunction = 3'd2,
    VCoil     = 3'd3,
    VAddress  = 3'd4,
    VRange    = 3'd5
  } verdict_e;

  // One captured request, as handed from front to back.
  typedef struct packed {
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] address;
    logic [15:0] quantity;
  } frame_t;

  // Configuration registers as seen by the checker.
  typedef struct packed {
    logic [7:0]  own_slave_id;
    logic [7:0]  served_function;
    logic [15:0] window_start;
    logic [15:0] window_length;
  } cfg_t;

endpackage

### rtl/modbus_rtu_request_validator_core.sv
// Channel   Direction  Handshake                  Payload
// bytes     in         push / full                rx_byte_i, frame_start_i
// results   out        empty / pop                verdict_o, request_address_o,
//                                                 request_quantity_o
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One request byte is taken every cycle while the front-to-back queue has room.
// A verdict reaches the result ports once the last byte of a request has passed
// through the two-entry queue and then through the checker's output register.
// Reset leaves the byte counter waiting for a frame start and the queue empty;
// the registers take their documented reset values. No clearing pass is needed.
// A stalled result side fills the queue and then raises full.
module modbus_rtu_request_validator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request bytes.
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  // Results.
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  verdict_o,
  output logic [15:0] request_address_o,
  output logic [15:0] request_quantity_o,
  // Configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mrv_pkg::cfg_t   cfg_q;
  mrv_pkg::frame_t q_wdata;
  mrv_pkg::frame_t q_rdata;
  logic            q_push;
  logic            q_pop;
  logic            q_empty;
  logic            cfg_wr;
  logic [1:0]      reg_idx;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_slave_id    <= 8'd1;
      cfg_q.served_function <= 8'd3;
      cfg_q.window_start    <= 16'd0;
      cfg_q.window_length   <= 16'd0;
    end else if (cfg_wr) begin
      case (reg_idx)
        mrv_pkg::RegOwnSlave:    cfg_q.own_slave_id    <= pwdata[7:0];
        mrv_pkg::RegServedFunc:  cfg_q.served_function <= pwdata[7:0];
        mrv_pkg::RegWindowStart: cfg_q.window_start    <= pwdata[15:0];
        mrv_pkg::RegWindowLen:   cfg_q.window_length   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      mrv_pkg::RegOwnSlave:    prdata = {24'd0, cfg_q.own_slave_id};
      mrv_pkg::RegServedFunc:  prdata = {24'd0, cfg_q.served_function};
      mrv_pkg::RegWindowStart: prdata = {16'd0, cfg_q.window_start};
      mrv_pkg::RegWindowLen:   prdata = {16'd0, cfg_q.window_length};
      default:                 prdata = '0;
    endcase
  end

  // Front: byte capture.
  mrv_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .q_push_o      (q_push),
    .q_wdata_o     (q_wdata)
  );

  // Queue between capture and checking.
  mrv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  // Back: checks and result register.
  mrv_judge u_judge (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .q_empty_i          (q_empty),
    .q_rdata_i          (q_rdata),
    .q_pop_o            (q_pop),
    .pop_i              (pop),
    .empty_o            (empty),
    .verdict_o          (verdict_o),
    .request_address_o  (request_address_o),
    .request_quantity_o (request_quantity_o)
  );

`ifndef ASSERT_OFF
  // An accepted coil or register write always targets the configured address.
  a_write_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && verdict_o == mrv_pkg::VOk &&
     (cfg_q.served_function == mrv_pkg::FcWriteCoil ||
      cfg_q.served_function == mrv_pkg::FcWriteReg))
    |-> request_address_o == cfg_q.window_start)
    else $error("accepted write does not match window start");

  // A new result only appears when the queue held a request.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(!q_empty))
    else $error("result appeared without a queued request");

  // The back side never drains an empty queue.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("checker popped an empty queue");
`endif

endmodule

### rtl/mrv_front.sv
module mrv_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic           full_i,
  input  logic [7:0]     rx_byte_i,
  input  logic           frame_start_i,
  output logic           q_push_o,
  output mrv_pkg::frame_t q_wdata_o
);

  logic [2:0]  pos_q, pos_d;
  logic [2:0]  pos_cur;
  logic [7:0]  slave_q;
  logic [7:0]  func_q;
  logic [7:0]  high_q;
  logic [15:0] addr_q;
  logic        accept;

  assign accept = push_i && !full_i;

  // A frame start always restarts capture at the slave id byte.
  assign pos_cur = frame_start_i ? mrv_pkg::PosSlave : pos_q;

  // Next byte position.
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      case (pos_cur)
        mrv_pkg::PosSlave:    pos_d = mrv_pkg::PosFunction;
        mrv_pkg::PosFunction: pos_d = mrv_pkg::PosAddrHigh;
        mrv_pkg::PosAddrHigh: pos_d = mrv_pkg::PosAddrLow;
        mrv_pkg::PosAddrLow:  pos_d = mrv_pkg::PosQtyHigh;
        mrv_pkg::PosQtyHigh:  pos_d = mrv_pkg::PosQtyLow;
        mrv_pkg::PosQtyLow:   pos_d = mrv_pkg::PosIdle;
        default:              pos_d = pos_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= mrv_pkg::PosIdle;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Field capture; each byte lands in the field its position selects.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      case (pos_cur)
        mrv_pkg::PosSlave:    slave_q <= rx_byte_i;
        mrv_pkg::PosFunction: func_q  <= rx_byte_i;
        mrv_pkg::PosAddrHigh: high_q  <= rx_byte_i;
        mrv_pkg::PosAddrLow:  addr_q  <= {high_q, rx_byte_i};
        mrv_pkg::PosQtyHigh:  high_q  <= rx_byte_i;
        default: ;
      endcase
    end
  end

  // The last byte of a request completes the record and queues it.
  assign q_push_o           = accept && (pos_cur == mrv_pkg::PosQtyLow);
  assign q_wdata_o.slave    = slave_q;
  assign q_wdata_o.func     = func_q;
  assign q_wdata_o.address  = addr_q;
  assign q_wdata_o.quantity = {high_q, rx_byte_i};

endmodule

### rtl/mrv_queue.sv
module mrv_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mrv_pkg::frame_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output mrv_pkg::frame_t rdata_o
);

  mrv_pkg::frame_t                 mem_q [mrv_pkg::QDepth];
  logic [mrv_pkg::QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [mrv_pkg::QCntW-1:0]       cnt_q;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == mrv_pkg::QCntW'(mrv_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == mrv_pkg::QPtrW'(mrv_pkg::QDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == mrv_pkg::QPtrW'(mrv_pkg::QDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### rtl/mrv_judge.sv
module mrv_judge (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mrv_pkg::cfg_t   cfg_i,
  input  logic            q_empty_i,
  input  mrv_pkg::frame_t q_rdata_i,
  output logic            q_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [2:0]      verdict_o,
  output logic [15:0]     request_address_o,
  output logic [15:0]     request_quantity_o
);

  mrv_pkg::verdict_e verdict;
  logic [16:0]       req_end;
  logic [16:0]       win_end;
  logic              out_valid_q;
  logic              load;
  logic [2:0]        verdict_q;
  logic [15:0]       addr_q;
  logic [15:0]       qty_q;

  // Range sums are kept at 17 bits so they never wrap.
  assign req_end = {1'b0, q_rdata_i.address} + {1'b0, q_rdata_i.quantity};
  assign win_end = {1'b0, cfg_i.window_start} + {1'b0, cfg_i.window_length};

  // Checks in priority order; the first failing one sets the verdict.
  always_comb begin
    if (q_rdata_i.slave != cfg_i.own_slave_id) begin
      verdict = mrv_pkg::VSlave;
    end else if (q_rdata_i.func != cfg_i.served_function) begin
      verdict = mrv_pkg::VFunction;
    end else if (cfg_i.served_function == mrv_pkg::FcWriteCoil) begin
      if (q_rdata_i.quantity != '0 && q_rdata_i.quantity != mrv_pkg::CoilOnValue) begin
        verdict = mrv_pkg::VCoil;
      end else if (q_rdata_i.address != cfg_i.window_start) begin
        verdict = mrv_pkg::VAddress;
      end else begin
        verdict = mrv_pkg::VOk;
      end
    end else if (cfg_i.served_function == mrv_pkg::FcWriteReg) begin
      if (q_rdata_i.address != cfg_i.window_start) begin
        verdict = mrv_pkg::VAddress;
      end else begin
        verdict = mrv_pkg::VOk;
      end
    end else if (req_end <= win_end && q_rdata_i.address >= cfg_i.window_start) begin
      verdict = mrv_pkg::VOk;
    end else begin
      verdict = mrv_pkg::VRange;
    end
  end

  // The output register takes a new request when empty or being drained.
  assign load    = !q_empty_i && (!out_valid_q || pop_i);
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      verdict_q <= verdict;
      addr_q    <= q_rdata_i.address;
      qty_q     <= q_rdata_i.quantity;
    end
  end

  assign empty_o            = !out_valid_q;
  assign verdict_o          = verdict_q;
  assign request_address_o  = addr_q;
  assign request_quantity_o = qty_q;

endmodule

### tb/modbus_rtu_request_validator_core_test.sv
`timescale 1ns / 1ps

module modbus_rtu_request_validator_core_test;

  localparam int CycleLimit = 400000;

  // One verdict as the result side should present it.
  typedef struct {
    mrv_pkg::verdict_e verdict;
    logic [15:0]       address;
    logic [15:0]       quantity;
  } verdict_t;

  // Tracks captured request bytes and keeps the verdicts still owed by the block.
  class verdict_board;
    logic [7:0]  own_slave = 8'd1;
    logic [7:0]  served_func = 8'd3;
    logic [15:0] window_start = 16'd0;
    logic [15:0] window_len = 16'd0;

    logic [2:0]  position = mrv_pkg::PosIdle;
    logic [7:0]  got_slave = '0;
    logic [7:0]  got_func = '0;
    logic [15:0] got_address = '0;
    logic [7:0]  got_high = '0;

    verdict_t    pending[$];
    int          mismatches = 0;

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        mrv_pkg::RegOwnSlave:    own_slave = value[7:0];
        mrv_pkg::RegServedFunc:  served_func = value[7:0];
        mrv_pkg::RegWindowStart: window_start = value[15:0];
        mrv_pkg::RegWindowLen:   window_len = value[15:0];
        default: ;
      endcase
    endfunction

    // The first failing check decides the verdict.
    function mrv_pkg::verdict_e judge(logic [15:0] addr, logic [15:0] qty);
      logic [16:0] reach;
      logic [16:0] bound;
      if (got_slave != own_slave) return mrv_pkg::VSlave;
      if (got_func != served_func) return mrv_pkg::VFunction;
      if (served_func == mrv_pkg::FcWriteCoil) begin
        if (qty != 16'd0 && qty != mrv_pkg::CoilOnValue) return mrv_pkg::VCoil;
        return (addr == window_start) ? mrv_pkg::VOk : mrv_pkg::VAddress;
      end
      if (served_func == mrv_pkg::FcWriteReg)
        return (addr == window_start) ? mrv_pkg::VOk : mrv_pkg::VAddress;
      // Read window, sums kept at 17 bits so nothing wraps.
      reach = {1'b0, addr} + {1'b0, qty};
      bound = {1'b0, window_start} + {1'b0, window_len};
      if (reach <= bound && addr >= window_start) return mrv_pkg::VOk;
      return mrv_pkg::VRange;
    endfunction

    // A frame start always restarts capture; bytes past the sixth are dropped.
    function void take_byte(logic [7:0] b, logic start);
      verdict_t    e;
      logic [15:0] qty;
      if (start) position = mrv_pkg::PosSlave;
      case (position)
        mrv_pkg::PosSlave: begin
          got_slave = b;
          position = mrv_pkg::PosFunction;
        end
        mrv_pkg::PosFunction: begin
          got_func = b;
          position = mrv_pkg::PosAddrHigh;
        end
        mrv_pkg::PosAddrHigh: begin
          got_high = b;
          position = mrv_pkg::PosAddrLow;
        end
        mrv_pkg::PosAddrLow: begin
          got_address = {got_high, b};
          position = mrv_pkg::PosQtyHigh;
        end
        mrv_pkg::PosQtyHigh: begin
          got_high = b;
          position = mrv_pkg::PosQtyLow;
        end
        mrv_pkg::PosQtyLow: begin
          qty = {got_high, b};
          position = mrv_pkg::PosIdle;
          e.verdict = judge(got_address, qty);
          e.address = got_address;
          e.quantity = qty;
          pending.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void match_result(logic [2:0] v, logic [15:0] a, logic [15:0] q);
      verdict_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: verdict %0d address %h quantity %h", v, a, q);
        return;
      end
      e = pending.pop_front();
      if (v !== e.verdict || a !== e.address || q !== e.quantity) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected verdict %0d address %h quantity %h, got %0d %h %h",
                   e.verdict, e.address, e.quantity, v, a, q);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte_i = '0;
  logic        frame_start_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  verdict_o;
  logic [15:0] request_address_o;
  logic [15:0] request_quantity_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  verdict_board board = new;
  int          tx_idle_pct = 36;
  int          rx_idle_pct = 36;
  int          rx_hold_left = 0;

  modbus_rtu_request_validator_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .rx_byte_i          (rx_byte_i),
    .frame_start_i      (frame_start_i),
    .empty              (empty),
    .pop                (pop),
    .verdict_o          (verdict_o),
    .request_address_o  (request_address_o),
    .request_quantity_o (request_quantity_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watch both handshakes at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) board.take_byte(rx_byte_i, frame_start_i);
      if (pop && !empty) board.match_result(verdict_o, request_address_o, request_quantity_o);
    end
  end

  // Result side: random stalls, plus a long hold-off when asked for.
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        pop = 1'b0;
        rx_hold_left--;
      end else begin
        pop = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Give up on a hung run.
  initial begin : watchdog
    int n;
    for (n = 0; n < CycleLimit; n++) @(posedge clk_i);
    $display("[modbus_rtu_request_validator_core] ERROR");
    $finish;
  end

  // Offer one request byte and hold it until the block takes it.
  task automatic send_byte(logic [7:0] b, logic start);
    while ($urandom_range(99) < tx_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push = 1'b1;
    rx_byte_i = b;
    frame_start_i = start;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  // Register write on the configuration port: setup phase, then access phase.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_reg(idx, value);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Stop sending and let every owed verdict come out, then settle.
  task automatic wait_drained();
    push = 1'b0;
    frame_start_i = 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Send the first cut bytes of a request.
  task automatic send_request(logic [7:0] s, logic [7:0] f, logic [15:0] a, logic [15:0] q,
                              int cut);
    logic [7:0] frame[6];
    int         i;
    frame = '{s, f, a[15:8], a[7:0], q[15:8], q[7:0]};
    for (i = 0; i < cut; i++) send_byte(frame[i], i == 0);
  endtask

  // Mostly well-formed requests aimed at the current window, some broken ones.
  task automatic random_requests(int count);
    int         k;
    int         j;
    int         lo;
    int         bound;
    int         a;
    int         q;
    int         cut;
    logic [7:0] s;
    logic [7:0] f;
    for (k = 0; k < count; k++) begin
      s = ($urandom_range(99) < 85) ? board.own_slave : 8'($urandom);
      f = ($urandom_range(99) < 85) ? board.served_func : 8'($urandom);
      lo = int'(board.window_start);
      bound = lo + int'(board.window_len);
      if (board.served_func == mrv_pkg::FcWriteCoil ||
          board.served_func == mrv_pkg::FcWriteReg) begin
        a = ($urandom_range(3) != 0) ? lo : int'($urandom_range(65535));
        case ($urandom_range(3))
          0: q = 0;
          1: q = int'(mrv_pkg::CoilOnValue);
          default: q = int'($urandom_range(65535));
        endcase
      end else begin
        a = lo + int'($urandom_range(int'(board.window_len)));
        if (a > 65535) a = 65535;
        q = int'($urandom_range((bound - a > 65535) ? 65535 : bound - a));
        case ($urandom_range(9))
          7: a = (lo + 65535) % 65536;
          8: q = (bound - a + 1 > 65535) ? 65535 : bound - a + 1;
          9: begin
            a = int'($urandom_range(65535));
            q = int'($urandom_range(65535));
          end
          default: ;
        endcase
      end
      cut = 6;
      if ($urandom_range(99) < 8) cut = int'($urandom_range(1, 5));
      send_request(s, f, 16'(a), 16'(q), cut);
      // Stray bytes without a frame start; ignored after a full request, they extend a truncated one.
      if ($urandom_range(99) < 6)
        for (j = int'($urandom_range(1, 3)); j > 0; j--) send_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic run_phase(logic [7:0] s, logic [7:0] f, logic [15:0] start,
                           logic [15:0] len, int count);
    write_reg(mrv_pkg::RegOwnSlave, {24'd0, s});
    write_reg(mrv_pkg::RegServedFunc, {24'd0, f});
    write_reg(mrv_pkg::RegWindowStart, {16'd0, start});
    write_reg(mrv_pkg::RegWindowLen, {16'd0, len});
    random_requests(count);
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed requests under reset settings (slave 1, function 3, empty window).
    send_request(8'h01, 8'h03, 16'h0000, 16'h0000, 6);  // empty read fits empty window
    send_byte(8'hFF, 1'b0);                              // ignored while idle
    send_request(8'h01, 8'h10, 16'h0000, 16'h0000, 2);  // partial, then restarted
    send_request(8'h01, 8'h04, 16'hFFFF, 16'hFFFF, 6);  // wrong function, all ones
    send_request(8'h01, 8'h03, 16'h0001, 16'h0000, 6);  // just outside the window
    send_byte(8'h00, 1'b0);
    send_request(8'h00, 8'h03, 16'h0000, 16'h0000, 3);  // truncated wrong slave
    wait_drained();

    // Read window with no idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(8'h11, 8'h03, 16'd100, 16'd50, 27);
    tx_idle_pct = 36;
    rx_idle_pct = 36;

    run_phase(8'h00, mrv_pkg::FcWriteCoil, 16'h1234, 16'h0000, 27);

    // Result side holds off so the block fills up and stalls its input.
    rx_hold_left = 250;
    run_phase(8'hFF, mrv_pkg::FcWriteReg, 16'hFFFF, 16'hFFFF, 27);

    run_phase(8'hA5, 8'h00, 16'h0000, 16'hFFFF, 27);
    run_phase(8'h07, 8'hFF, 16'hFF00, 16'h00FF, 27);
    run_phase(8'($urandom), 8'($urandom_range(1, 6)), 16'($urandom), 16'($urandom), 27);

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("[modbus_rtu_request_validator_core] OK");
    end else begin
      $display("[modbus_rtu_request_validator_core] ERROR");
    end
    $finish;
  end

endmodule
